>>> src/cd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cd_pkg
// Operation and status codes, and the command bundle sent to the cell row.
// ----------------------------------------------------------------------------
package cd_pkg;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int PORT_WIDTH = 32;

    // One strobe per successful operation; at most one is high in a cycle.
    typedef struct packed {
        logic put_front;
        logic put_back;
        logic get_front;
        logic get_back;
    } cmd_t;

endpackage

>>> src/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Fixed-depth double-ended queue with push and pop at either end.
// ----------------------------------------------------------------------------
// The deque takes one operation word per clock and returns one result word
// per operation, registered: the result appears the cycle after the
// operation is taken, and in_ready stays high whenever the result register
// is empty or is being emptied in the same cycle, so a steady stream runs at
// one operation per cycle. The storage is a row of DEPTH cells, entries kept
// packed from cell 0 (front) upwards; every successful operation updates the
// whole row at once (a push at the front shifts all words one cell
// back, a pop at the front shifts them one cell forward, a push at the back
// fills the first free cell, a pop at the back clears the last occupied one).
// Full and empty follow straight from the occupied bits of the end cells. A
// push to a full deque returns status 1 and a pop from an empty deque returns
// status 2 with a zero word; neither changes the contents. Words are kept at
// DATA_WIDTH bits (at most the port width) and returned zero-extended.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] push_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pop_value,
    output logic [1:0]  status,
    output logic        now_empty,
    output logic        now_full
);
    import cd_pkg::*;

    // stored word width: nothing beyond the port width can ever arrive
    localparam int SW = (DATA_WIDTH < PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;

    logic             take;
    logic             full_now;
    logic             empty_now;
    cmd_t             cmd;
    logic [SW-1:0]    word;
    logic [SW-1:0]    back_word;
    logic [SW-1:0]    pop_word;
    logic [1:0]       status_next;
    logic             empty_after;
    logic             full_after;

    logic [DEPTH-1:0] occ_vec;
    logic [SW-1:0]    cell_data [DEPTH];
    logic [SW-1:0]    back_tap  [DEPTH];

    logic             out_valid_reg;
    logic [31:0]      pop_value_reg;
    logic [1:0]       status_reg;
    logic             now_empty_reg;
    logic             now_full_reg;

    // Accept whenever the result register is free or drains this cycle
    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign word      = push_value[SW-1:0];
    assign full_now  = occ_vec[DEPTH-1];
    assign empty_now = !occ_vec[0];

    // Decode the operation; rejected operations raise no strobe
    always_comb
    begin
        cmd         = '0;
        status_next = ST_DONE;
        case (operation)
            OP_PUSH_FRONT:
            begin
                cmd.put_front = take && !full_now;
                status_next   = full_now ? ST_FULL : ST_DONE;
            end
            OP_PUSH_BACK:
            begin
                cmd.put_back = take && !full_now;
                status_next  = full_now ? ST_FULL : ST_DONE;
            end
            OP_POP_FRONT:
            begin
                cmd.get_front = take && !empty_now;
                status_next   = empty_now ? ST_EMPTY : ST_DONE;
            end
            OP_POP_BACK:
            begin
                cmd.get_back = take && !empty_now;
                status_next  = empty_now ? ST_EMPTY : ST_DONE;
            end
            default:
            begin
                cmd         = '0;
                status_next = ST_DONE;
            end
        endcase
    end

    // Row of cells: cell 0 holds the front; the word enters from the left
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic          l_occ;
            logic [SW-1:0] l_data;
            logic          r_occ;
            logic [SW-1:0] r_data;

            if (gi == 0)
            begin : g_first
                assign l_occ  = 1'b1;
                assign l_data = word;
            end
            else
            begin : g_mid_l
                assign l_occ  = occ_vec[gi-1];
                assign l_data = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_occ  = 1'b0;
                assign r_data = '0;
            end
            else
            begin : g_mid_r
                assign r_occ  = occ_vec[gi+1];
                assign r_data = cell_data[gi+1];
            end

            cd_cell #(
                .W (SW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .word       (word),
                .left_occ   (l_occ),
                .left_data  (l_data),
                .right_occ  (r_occ),
                .right_data (r_data),
                .occ        (occ_vec[gi]),
                .data       (cell_data[gi]),
                .back_data  (back_tap[gi])
            );
        end
    endgenerate

    // Only the last occupied cell drives its word onto the tap; all other taps are zero
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word = back_word | back_tap[i];
        end
    end

    always_comb
    begin
        pop_word = '0;
        if (cmd.get_front)
        begin
            pop_word = cell_data[0];
        end
        else if (cmd.get_back)
        begin
            pop_word = back_word;
        end
    end

    // Flags as they stand once this operation has taken effect
    always_comb
    begin
        empty_after = empty_now;
        full_after  = full_now;
        if (cmd.put_front || cmd.put_back)
        begin
            empty_after = 1'b0;
            full_after  = occ_vec[DEPTH-2];
        end
        else if (cmd.get_front || cmd.get_back)
        begin
            empty_after = !occ_vec[1];
            full_after  = 1'b0;
        end
    end

    // Result register: hold until taken, load on every accepted operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pop_value_reg <= 32'(pop_word);
            status_reg    <= status_next;
            now_empty_reg <= empty_after;
            now_full_reg  <= full_after;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign now_empty = now_empty_reg;
    assign now_full  = now_full_reg;

    // Occupied cells stay packed from the front
    a_packed_row : assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec[DEPTH-1:1] & ~occ_vec[DEPTH-2:0]) == '0)
        else $error("occupied cells not contiguous from the front");

    // A rejected push only ever reports a full deque
    a_reject_full : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (now_full && !now_empty))
        else $error("push rejected while deque not full");

    // A rejected pop returns a zero word from an empty deque
    a_reject_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (now_empty && pop_value == '0))
        else $error("pop rejected with bad flags or word");

    // Flags after an accepted operation match the cell row in the following cycle
    a_flags_track : assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (now_empty == !occ_vec[0] && now_full == occ_vec[DEPTH-1]))
        else $error("reported flags disagree with the cell row");

endmodule

>>> src/cd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cd_cell
// One position of the deque: an occupied bit and a data word, fed from the
// neighbour on either side.
// ----------------------------------------------------------------------------
module cd_cell #(
    parameter int W = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cd_pkg::cmd_t    cmd,
    input  logic [W-1:0]    word,
    input  logic            left_occ,
    input  logic [W-1:0]    left_data,
    input  logic            right_occ,
    input  logic [W-1:0]    right_data,
    output logic            occ,
    output logic [W-1:0]    data,
    output logic [W-1:0]    back_data
);
    import cd_pkg::*;

    logic         occ_reg;
    logic         occ_next;
    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.put_front || cmd.put_back)
        begin
            occ_next = left_occ;
        end
        else if (cmd.get_front || cmd.get_back)
        begin
            occ_next = right_occ;
        end
    end

    always_comb
    begin
        data_next = data_reg;
        if (cmd.put_front)
        begin
            data_next = left_data;
        end
        else if (cmd.put_back && !occ_reg && left_occ)
        begin
            data_next = word;
        end
        else if (cmd.get_front)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign occ       = occ_reg;
    assign data      = data_reg;
    // last occupied cell drives the back word
    assign back_data = (occ_reg && !right_occ) ? data_reg : '0;

endmodule

>>> test/circular_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the double-ended queue.
// ----------------------------------------------------------------------------
// Every accepted operation word is run through a behavioural copy of the
// deque: a plain queue of held words, bounded at DEPTH. The copy produces the
// result word the block should return, and these wait in order until the
// block's results come back and are compared field by field. A short
// directed opening covers pops on empty, pushes into empty at either end,
// filling to full, pushes rejected when full, and data extremes. A long
// random run follows. It leans towards filling or draining in phases, so
// the deque swings between empty and full many times. The sender works in
// bursts with gaps, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module circular_deque_tb;

    import cd_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int RANDOM_OPS  = 1150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    localparam logic [31:0] WORD_MASK =
        (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << DATA_WIDTH) - 32'd1);

    // Lean of the random operation mix.
    localparam logic [1:0] LEAN_FILL  = 2'd0;
    localparam logic [1:0] LEAN_DRAIN = 2'd1;
    localparam logic [1:0] LEAN_EVEN  = 2'd2;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  st;
        logic        empty;
        logic        full;
    } deque_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: behavioural deque plus the results still owed by the block.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [31:0]   held_words[$];
        deque_result_t owed_results[$];
        int            failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted operation to the deque image and queue its result.
        function void note_operation(logic [1:0] op, logic [31:0] value);
            deque_result_t res;
            logic [31:0]   word;
            word = value & WORD_MASK;
            res  = '0;
            res.st = ST_DONE;
            if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
            begin
                if (held_words.size() >= DEPTH)
                    res.st = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    held_words.insert(0, word);
                else
                    held_words.insert(held_words.size(), word);
            end
            else
            begin
                if (held_words.size() == 0)
                    res.st = ST_EMPTY;
                else if (op == OP_POP_FRONT)
                begin
                    res.word = held_words[0];
                    held_words.delete(0);
                end
                else
                begin
                    res.word = held_words[held_words.size() - 1];
                    held_words.delete(held_words.size() - 1);
                end
            end
            res.empty = (held_words.size() == 0);
            res.full  = (held_words.size() >= DEPTH);
            owed_results.insert(owed_results.size(), res);
        endfunction

        // Compare one returned result word with the oldest one owed.
        function void check_result(logic [31:0] word, logic [1:0] st,
                                   logic empty, logic full);
            deque_result_t want;
            if (owed_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: word %h status %0d empty %b full %b",
                             word, st, empty, full);
                return;
            end
            want = owed_results[0];
            owed_results.delete(0);
            if (word !== want.word || st !== want.st ||
                empty !== want.empty || full !== want.full)
            begin
                failures++;
                // fields in order: word, status, empty, full
                if (failures <= REPORT_MAX)
                    $display("mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                             want.word, want.st, want.empty, want.full,
                             word, st, empty, full);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] push_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pop_value;
    logic [1:0]  status;
    logic        now_empty;
    logic        now_full;

    int unsigned     cycle_count;
    deque_scoreboard board;

    circular_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status),
        .now_empty  (now_empty),
        .now_full   (now_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run as failed once the cycle counter reaches its limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sample both channels at the edge; values seen here are those before
    // the edge, so the order of processes within the step does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_operation(operation, push_value);
            if (out_valid && out_ready)
                board.check_result(pop_value, status, now_empty, now_full);
        end
    end

    // Receiver: short ready runs broken by stalls, with the odd long
    // stretch of steady ready so that back-to-back results are seen too.
    initial
    begin
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    // Present one operation word and hold it until the block takes it.
    // Returns on the accepting edge with valid still high.
    task automatic drive_op(input logic [1:0] op, input logic [31:0] value);
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid for a number of cycles; scramble the idle payload.
    task automatic idle_sender(input int cycles);
        in_valid   <= 1'b0;
        operation  <= 2'($urandom);
        push_value <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_op(input logic [1:0] lean);
        int  roll;
        bit  push;
        bit  at_back;
        roll    = $urandom_range(0, 99);
        at_back = $urandom_range(0, 1);
        case (lean)
            LEAN_FILL:  push = (roll < 75);
            LEAN_DRAIN: push = (roll < 25);
            default:    push = (roll < 50);
        endcase
        if (push)
            return at_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return at_back ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // Opening sequence: the corners of the deque's behaviour.
    task automatic run_directed();
        // pops on an empty deque are rejected with a zero word
        drive_op(OP_POP_FRONT, 32'hFFFF_FFFF);
        drive_op(OP_POP_BACK, 32'h0000_0000);
        // single entry pushed at one end must be visible at the other
        drive_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        drive_op(OP_POP_BACK, 32'h0000_0000);
        drive_op(OP_PUSH_BACK, 32'h0000_0000);
        drive_op(OP_POP_FRONT, 32'hFFFF_FFFF);
        // fill from both ends with walking patterns until the deque is full
        for (int i = 0; i < DEPTH; i++)
            drive_op(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                     (32'h1 << i) | (32'h8000_0000 >> i));
        // pushes to a full deque are rejected
        drive_op(OP_PUSH_FRONT, 32'hA5A5_A5A5);
        drive_op(OP_PUSH_BACK, 32'h5A5A_5A5A);
        drive_op(OP_POP_FRONT, 32'h0000_0000);
        drive_op(OP_POP_BACK, 32'h0000_0000);
    endtask

    // Random run in bursts; the mix leans towards filling or draining in
    // phases so that full and empty are both reached again and again.
    task automatic run_random(input int total);
        int         sent;
        int         burst;
        int         phase_left;
        logic [1:0] lean;
        sent       = 0;
        phase_left = 0;
        lean       = LEAN_EVEN;
        while (sent < total)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < total)
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(10, 60);
                    lean       = 2'($urandom_range(0, 2));
                end
                drive_op(pick_op(lean), pick_value());
                sent++;
                burst--;
                phase_left--;
                // hold the sender once until the pipeline is empty
                if (sent == total / 2)
                    drain_results();
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        board       = new();
        cycle_count = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= OP_PUSH_FRONT;
        push_value  <= 32'h0;
        out_ready   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_OPS);

        // wait out the last results, then allow for the output register
        drain_results();
        repeat (5) @(posedge clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
